[rtl/ctsq_pkg.sv]
// Shared types, codes and reset values for the camera trigger sequencer.
package ctsq_pkg;

    localparam int unsigned PW_W    = 10;
    localparam int unsigned PRE_W   = 13;
    localparam int unsigned POST_W  = 14;
    localparam int unsigned TMO_W   = 16;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_TEST  = 2'd2
    } t_cmd;

    typedef enum logic [CIDX_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_PULSE_W   = 3'd1,
        REG_PRE_DLY   = 3'd2,
        REG_POST_DLY  = 3'd3,
        REG_READY_TMO = 3'd4,
        REG_USE_READY = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_PULSE = 3'd2,
        PH_READY = 3'd3,
        PH_POST  = 3'd4
    } t_phase;

    localparam logic              RST_ENABLE    = 1'b1;
    localparam logic [PW_W-1:0]   RST_PULSE_W   = 10'd50;
    localparam logic [PRE_W-1:0]  RST_PRE_DLY   = 13'd100;
    localparam logic [POST_W-1:0] RST_POST_DLY  = 14'd100;
    localparam logic [TMO_W-1:0]  RST_READY_TMO = 16'd5000;
    localparam logic              RST_USE_READY = 1'b0;

    typedef struct packed {
        logic              enable;
        logic [PW_W-1:0]   pulse_width;
        logic [PRE_W-1:0]  pre_delay;
        logic [POST_W-1:0] post_delay;
        logic [TMO_W-1:0]  ready_timeout;
        logic              use_ready;
    } t_cfg;

    typedef struct packed {
        logic             trigger_level;
        logic             active;
        logic             done_res;
        logic             success;
        logic [CNT_W-1:0] trigger_total;
        logic [CNT_W-1:0] last_pulse_time;
    } t_result;

    // a zero width still gives a one-tick pulse
    function automatic logic [PW_W-1:0] pulse_fix(input logic [PW_W-1:0] w);
        pulse_fix = (w == '0) ? PW_W'(1) : w;
    endfunction

endpackage

[rtl/ctsq_cfg.sv]
// Configuration register file of the camera trigger sequencer.
module ctsq_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ctsq_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [ctsq_pkg::CDATA_W-1:0]  i_cfg_data,
    output ctsq_pkg::t_cfg                o_cfg
);
    import ctsq_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= RST_ENABLE;
            r_cfg.pulse_width   <= RST_PULSE_W;
            r_cfg.pre_delay     <= RST_PRE_DLY;
            r_cfg.post_delay    <= RST_POST_DLY;
            r_cfg.ready_timeout <= RST_READY_TMO;
            r_cfg.use_ready     <= RST_USE_READY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE:    r_cfg.enable        <= i_cfg_data[0];
                REG_PULSE_W:   r_cfg.pulse_width   <= i_cfg_data[PW_W-1:0];
                REG_PRE_DLY:   r_cfg.pre_delay     <= i_cfg_data[PRE_W-1:0];
                REG_POST_DLY:  r_cfg.post_delay    <= i_cfg_data[POST_W-1:0];
                REG_READY_TMO: r_cfg.ready_timeout <= i_cfg_data[TMO_W-1:0];
                REG_USE_READY: r_cfg.use_ready     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/ctsq_core.sv]
// Sequencer state machine, tick clock and pulse statistics.
module ctsq_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ctsq_pkg::t_cfg               i_cfg,
    input  logic                         i_accept,
    input  logic [ctsq_pkg::CMD_W-1:0]   i_cmd,
    input  logic                         i_wait_ready,
    input  logic [ctsq_pkg::PW_W-1:0]    i_custom_width,
    input  logic                         i_camera_busy,
    output ctsq_pkg::t_result            o_result
);
    import ctsq_pkg::*;

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [PW_W-1:0]   r_len, n_len;
    logic              r_full, n_full;
    logic              r_wait, n_wait;
    logic [CNT_W-1:0]  r_clock, n_clock;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_last, n_last;

    logic              fin_done, fin_ok;
    logic [TICK_W-1:0] ticks_inc;
    logic              post_zero;
    logic [PW_W-1:0]   test_width;

    assign ticks_inc  = r_ticks + TICK_W'(1);
    assign post_zero  = (i_cfg.post_delay == '0);
    assign test_width = (i_custom_width != '0) ? i_custom_width : i_cfg.pulse_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
            r_len   <= '0;
            r_full  <= 1'b0;
            r_wait  <= 1'b0;
            r_clock <= '0;
            r_count <= '0;
            r_last  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_len   <= n_len;
            r_full  <= n_full;
            r_wait  <= n_wait;
            r_clock <= n_clock;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_ticks  = r_ticks;
        n_len    = r_len;
        n_full   = r_full;
        n_wait   = r_wait;
        n_clock  = r_clock;
        n_count  = r_count;
        n_last   = r_last;
        fin_done = 1'b0;
        fin_ok   = 1'b0;

        unique case (i_cmd)
            CMD_TICK: begin
                n_clock = r_clock + CNT_W'(1);
                unique case (r_phase)
                    PH_PRE: begin
                        n_ticks = ticks_inc;
                        if (ticks_inc >= TICK_W'(i_cfg.pre_delay)) begin
                            n_phase = PH_PULSE;
                            n_ticks = '0;
                            n_len   = pulse_fix(i_cfg.pulse_width);
                        end
                    end
                    PH_PULSE: begin
                        n_ticks = ticks_inc;
                        if (ticks_inc >= TICK_W'(r_len)) begin
                            // pulse ends: count it and stamp the tick time
                            n_count = r_count + CNT_W'(1);
                            n_last  = n_clock;
                            n_ticks = '0;
                            if (!r_full) begin
                                n_phase  = PH_IDLE;
                                fin_done = 1'b1;
                                fin_ok   = 1'b1;
                            end else if (r_wait && i_camera_busy) begin
                                n_phase = PH_READY;
                            end else if (post_zero) begin
                                n_phase  = PH_IDLE;
                                fin_done = 1'b1;
                                fin_ok   = 1'b1;
                            end else begin
                                n_phase = PH_POST;
                            end
                        end
                    end
                    PH_READY: begin
                        if (!i_camera_busy) begin
                            n_ticks = '0;
                            if (post_zero) begin
                                n_phase  = PH_IDLE;
                                fin_done = 1'b1;
                                fin_ok   = 1'b1;
                            end else begin
                                n_phase = PH_POST;
                            end
                        end else if (r_ticks >= i_cfg.ready_timeout) begin
                            n_phase  = PH_IDLE;
                            n_ticks  = '0;
                            fin_done = 1'b1;
                        end else begin
                            n_ticks = ticks_inc;
                        end
                    end
                    PH_POST: begin
                        n_ticks = ticks_inc;
                        if (ticks_inc >= TICK_W'(i_cfg.post_delay)) begin
                            n_phase  = PH_IDLE;
                            n_ticks  = '0;
                            fin_done = 1'b1;
                            fin_ok   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_START: begin
                if (r_phase == PH_IDLE) begin
                    if (!i_cfg.enable) begin
                        n_ticks  = '0;
                        fin_done = 1'b1;
                        fin_ok   = 1'b1;
                    end else begin
                        n_full  = 1'b1;
                        n_wait  = i_wait_ready & i_cfg.use_ready;
                        n_ticks = '0;
                        if (i_cfg.pre_delay == '0) begin
                            n_phase = PH_PULSE;
                            n_len   = pulse_fix(i_cfg.pulse_width);
                        end else begin
                            n_phase = PH_PRE;
                        end
                    end
                end
            end
            CMD_TEST: begin
                if (r_phase == PH_IDLE) begin
                    n_full  = 1'b0;
                    n_wait  = 1'b0;
                    n_phase = PH_PULSE;
                    n_ticks = '0;
                    n_len   = pulse_fix(test_width);
                end
            end
            default: begin
            end
        endcase

        o_result.trigger_level   = (n_phase == PH_PULSE);
        o_result.active          = (n_phase != PH_IDLE);
        o_result.done_res        = fin_done;
        o_result.success         = fin_ok;
        o_result.trigger_total   = n_count;
        o_result.last_pulse_time = n_last;
    end

endmodule

[rtl/camera_trigger_sequencer.sv]
// Top level of the camera trigger sequencer: config port, core and result register.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+--------------------------------------------
//  request | i_in_valid | o_in_ready  | i_cmd, i_wait_ready, i_custom_width,
//          |            |             | i_camera_busy
//  result  | o_out_valid| i_out_ready | o_trigger_level, o_active, o_done_res,
//          |            |             | o_success, o_trigger_total, o_last_pulse_time
//  config  | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_ready is high; its result appears in the result register on the next cycle.
// The sequencer state updates at the accepting edge in a single pass of logic.
// A request is taken whenever the result register is empty or being drained.
// Reset is synchronous, active low, and loads the register defaults; config is always ready.
module camera_trigger_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ctsq_pkg::CMD_W-1:0]    i_cmd,
    input  logic                          i_wait_ready,
    input  logic [ctsq_pkg::PW_W-1:0]     i_custom_width,
    input  logic                          i_camera_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_trigger_level,
    output logic                          o_active,
    output logic                          o_done_res,
    output logic                          o_success,
    output logic [ctsq_pkg::CNT_W-1:0]    o_trigger_total,
    output logic [ctsq_pkg::CNT_W-1:0]    o_last_pulse_time,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ctsq_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [ctsq_pkg::CDATA_W-1:0]  i_cfg_data
);
    import ctsq_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    ctsq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ctsq_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (accept),
        .i_cmd          (i_cmd),
        .i_wait_ready   (i_wait_ready),
        .i_custom_width (i_custom_width),
        .i_camera_busy  (i_camera_busy),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_trigger_level   = r_out.trigger_level;
    assign o_active          = r_out.active;
    assign o_done_res        = r_out.done_res;
    assign o_success         = r_out.success;
    assign o_trigger_total   = r_out.trigger_total;
    assign o_last_pulse_time = r_out.last_pulse_time;

endmodule

[sim/camera_trigger_sequencer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the camera trigger sequencer: directed and random requests.
module camera_trigger_sequencer_tb;

    import ctsq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int unsigned      CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             wait_ready;
        logic [PW_W-1:0]  width;
        logic             busy;
    } t_req;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_cmd          = '0;
    logic                 i_wait_ready   = 1'b0;
    logic [PW_W-1:0]      i_custom_width = '0;
    logic                 i_camera_busy  = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic                 o_trigger_level;
    logic                 o_active;
    logic                 o_done_res;
    logic                 o_success;
    logic [CNT_W-1:0]     o_trigger_total;
    logic [CNT_W-1:0]     o_last_pulse_time;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CIDX_W-1:0]    i_cfg_index    = '0;
    logic [CDATA_W-1:0]   i_cfg_data     = '0;

    camera_trigger_sequencer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_wait_ready      (i_wait_ready),
        .i_custom_width    (i_custom_width),
        .i_camera_busy     (i_camera_busy),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_trigger_level   (o_trigger_level),
        .o_active          (o_active),
        .o_done_res        (o_done_res),
        .o_success         (o_success),
        .o_trigger_total   (o_trigger_total),
        .o_last_pulse_time (o_last_pulse_time),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_req        request_q[$];
    t_result     awaited_results[$];
    int unsigned requests_queued = 0;
    int unsigned results_seen    = 0;
    int unsigned err_cnt         = 0;
    int unsigned in_gap_max      = 17;
    int unsigned out_gap_max     = 17;
    int unsigned in_wait         = 0;
    int unsigned out_wait        = 0;
    int unsigned long_holds      = 0;
    int unsigned cycle_cnt       = 0;

    // sequencer mirror
    t_cfg            cfg_m;
    t_phase          seq_ph;
    int unsigned     seq_ticks;
    logic [PW_W-1:0] seq_len;
    logic            seq_full;
    logic            seq_wait;
    logic [CNT_W-1:0] tick_now;
    logic [CNT_W-1:0] pulses_sent;
    logic [CNT_W-1:0] last_end;
    logic            fin_flag;
    logic            fin_ok;

    function automatic int unsigned pick_gap(input int unsigned top);
        if (top == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, top);
    endfunction

    task automatic seq_done(input logic ok);
        seq_ph    = PH_IDLE;
        seq_ticks = 0;
        fin_flag  = 1'b1;
        fin_ok    = ok;
    endtask

    task automatic seq_post();
        if (cfg_m.post_delay == '0) begin
            seq_done(1'b1);
        end else begin
            seq_ph    = PH_POST;
            seq_ticks = 0;
        end
    endtask

    task automatic seq_pulse(input logic [PW_W-1:0] len);
        seq_ph    = PH_PULSE;
        seq_ticks = 0;
        seq_len   = (len == '0) ? PW_W'(1) : len;
    endtask

    task automatic pulse_over(input logic busy);
        pulses_sent = pulses_sent + 1;
        last_end    = tick_now;
        if (!seq_full) begin
            seq_done(1'b1);
        end else if (seq_wait) begin
            seq_ph    = PH_READY;
            seq_ticks = 0;
            if (!busy)
                seq_post();
        end else begin
            seq_post();
        end
    endtask

    task automatic advance_sequencer(input t_req r, output t_result res);
        fin_flag = 1'b0;
        fin_ok   = 1'b0;
        case (r.cmd)
            CMD_TICK: begin
                tick_now = tick_now + 1;
                case (seq_ph)
                    PH_PRE: begin
                        seq_ticks++;
                        if (seq_ticks >= cfg_m.pre_delay)
                            seq_pulse(cfg_m.pulse_width);
                    end
                    PH_PULSE: begin
                        seq_ticks++;
                        if (seq_ticks >= seq_len)
                            pulse_over(r.busy);
                    end
                    PH_READY: begin
                        if (!r.busy)
                            seq_post();
                        else if (seq_ticks >= cfg_m.ready_timeout)
                            seq_done(1'b0);
                        else
                            seq_ticks++;
                    end
                    PH_POST: begin
                        seq_ticks++;
                        if (seq_ticks >= cfg_m.post_delay)
                            seq_done(1'b1);
                    end
                    default: ;
                endcase
            end
            CMD_START: begin
                if (seq_ph == PH_IDLE) begin
                    if (!cfg_m.enable) begin
                        seq_done(1'b1);
                    end else begin
                        seq_full = 1'b1;
                        seq_wait = r.wait_ready & cfg_m.use_ready;
                        if (cfg_m.pre_delay == '0) begin
                            seq_pulse(cfg_m.pulse_width);
                        end else begin
                            seq_ph    = PH_PRE;
                            seq_ticks = 0;
                        end
                    end
                end
            end
            CMD_TEST: begin
                if (seq_ph == PH_IDLE) begin
                    seq_full = 1'b0;
                    seq_wait = 1'b0;
                    seq_pulse((r.width != '0) ? r.width : cfg_m.pulse_width);
                end
            end
            default: ;
        endcase
        res.trigger_level   = (seq_ph == PH_PULSE);
        res.active          = (seq_ph != PH_IDLE);
        res.done_res        = fin_flag;
        res.success         = fin_ok;
        res.trigger_total   = pulses_sent;
        res.last_pulse_time = last_end;
    endtask

    // mirror config writes and predict each accepted request
    always @(posedge i_clk) begin : predict
        t_result want;
        if (!i_rst_n) begin
            cfg_m.enable        = RST_ENABLE;
            cfg_m.pulse_width   = RST_PULSE_W;
            cfg_m.pre_delay     = RST_PRE_DLY;
            cfg_m.post_delay    = RST_POST_DLY;
            cfg_m.ready_timeout = RST_READY_TMO;
            cfg_m.use_ready     = RST_USE_READY;
            seq_ph      = PH_IDLE;
            seq_ticks   = 0;
            seq_len     = '0;
            seq_full    = 1'b0;
            seq_wait    = 1'b0;
            tick_now    = '0;
            pulses_sent = '0;
            last_end    = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ENABLE:    cfg_m.enable        = i_cfg_data[0];
                    REG_PULSE_W:   cfg_m.pulse_width   = i_cfg_data[PW_W-1:0];
                    REG_PRE_DLY:   cfg_m.pre_delay     = i_cfg_data[PRE_W-1:0];
                    REG_POST_DLY:  cfg_m.post_delay    = i_cfg_data[POST_W-1:0];
                    REG_READY_TMO: cfg_m.ready_timeout = i_cfg_data[TMO_W-1:0];
                    REG_USE_READY: cfg_m.use_ready     = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                advance_sequencer(t_req'{i_cmd, i_wait_ready, i_custom_width, i_camera_busy},
                                  want);
                awaited_results.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin : request_drive
        t_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the request until taken
        end else if (in_wait != 0) begin
            i_in_valid <= 1'b0;
            in_wait    <= in_wait - 1;
        end else if (request_q.size() != 0) begin
            nxt = request_q.pop_front();
            i_in_valid     <= 1'b1;
            i_cmd          <= nxt.cmd;
            i_wait_ready   <= nxt.wait_ready;
            i_custom_width <= nxt.width;
            i_camera_busy  <= nxt.busy;
            in_wait        <= pick_gap(in_gap_max);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        int unsigned stall;
        stall = 0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_trigger_level, o_active, o_done_res, o_success,
                        o_trigger_total, o_last_pulse_time};
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    err_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.trigger_level !== want.trigger_level) begin
                        $error("trigger_level: expected %0d, got %0d",
                               want.trigger_level, got.trigger_level);
                        err_cnt++;
                    end
                    if (got.active !== want.active) begin
                        $error("active: expected %0d, got %0d", want.active, got.active);
                        err_cnt++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                        err_cnt++;
                    end
                    if (got.success !== want.success) begin
                        $error("success: expected %0d, got %0d", want.success, got.success);
                        err_cnt++;
                    end
                    if (got.trigger_total !== want.trigger_total) begin
                        $error("trigger_total: expected %0d, got %0d",
                               want.trigger_total, got.trigger_total);
                        err_cnt++;
                    end
                    if (got.last_pulse_time !== want.last_pulse_time) begin
                        $error("last_pulse_time: expected %0d, got %0d",
                               want.last_pulse_time, got.last_pulse_time);
                        err_cnt++;
                    end
                end
                // back up the block now and then while requests keep coming
                if (long_holds < 2 && request_q.size() >= 40 &&
                    results_seen >= 200 + 400 * long_holds) begin
                    stall = 300;
                    long_holds++;
                end else begin
                    stall = pick_gap(out_gap_max);
                end
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                out_wait    <= stall - 1;
            end else if (out_wait != 0) begin
                i_out_ready <= 1'b0;
                out_wait    <= out_wait - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_req(input t_req r);
        request_q.push_back(r);
        requests_queued++;
    endtask

    task automatic push(input logic [CMD_W-1:0] c, input logic wr,
                        input logic [PW_W-1:0] cw, input logic busy);
        push_req('{c, wr, cw, busy});
    endtask

    task automatic push_ticks(input int unsigned n, input logic busy);
        for (int unsigned k = 0; k < n; k++)
            push(CMD_TICK, 1'($urandom_range(0, 1)), PW_W'($urandom_range(0, 1000)), busy);
    endtask

    // wait until every queued request has produced its result
    task automatic drain();
        while (results_seen < requests_queued)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CDATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic en, input logic [CDATA_W-1:0] pw,
                              input logic [CDATA_W-1:0] pre, input logic [CDATA_W-1:0] post,
                              input logic [CDATA_W-1:0] tmo, input logic use_rdy);
        write_reg(REG_ENABLE, CDATA_W'(en));
        write_reg(REG_PULSE_W, pw);
        write_reg(REG_PRE_DLY, pre);
        write_reg(REG_POST_DLY, post);
        write_reg(REG_READY_TMO, tmo);
        write_reg(REG_USE_READY, CDATA_W'(use_rdy));
    endtask

    function automatic t_req rand_item();
        t_req r;
        int unsigned sel;
        sel          = $urandom_range(0, 99);
        r.wait_ready = 1'($urandom_range(0, 1));
        r.busy       = 1'($urandom_range(0, 1));
        r.width      = PW_W'($urandom_range(0, 1000));
        if (sel < 70) begin
            r.cmd = CMD_TICK;
        end else if (sel < 84) begin
            r.cmd = CMD_START;
        end else if (sel < 97) begin
            r.cmd   = CMD_TEST;
            // keep test pulses short so sequences keep turning over
            r.width = ($urandom_range(0, 3) == 0) ? PW_W'($urandom_range(0, 20))
                                                  : PW_W'($urandom_range(0, 4));
        end else begin
            r.cmd = CMD_UNUSED;
        end
        return r;
    endfunction

    initial begin : stimulus
        int unsigned ph_idx;
        int unsigned k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: short test pulse
        push(CMD_TICK, 1'b0, 10'd0, 1'b0);
        push(CMD_TEST, 1'b0, 10'd2, 1'b1);
        push_ticks(2, 1'b0);
        drain();

        set_config(1'b1, 16'd3, 16'd2, 16'd2, 16'd3, 1'b1);
        push(CMD_TICK, 1'b0, 10'd0, 1'b0);
        push(CMD_START, 1'b1, 10'd0, 1'b0);
        push(CMD_START, 1'b1, 10'd0, 1'b0);      // ignored while running
        push_ticks(1, 1'b0);
        push(CMD_TEST, 1'b0, 10'd5, 1'b0);       // ignored while running
        push(CMD_UNUSED, 1'b1, 10'd1000, 1'b1);  // no effect, no time
        push_ticks(3, 1'b0);
        push_ticks(1, 1'b1);                     // pulse ends with camera busy
        push_ticks(4, 1'b1);                     // ready wait times out
        push(CMD_START, 1'b0, 10'd0, 1'b0);
        push_ticks(7, 1'b0);
        push(CMD_TEST, 1'b0, 10'd0, 1'b0);       // configured width
        push_ticks(3, 1'b0);
        drain();

        // large settings, then lower live registers under a running sequence
        set_config(1'b1, 16'd1000, 16'd5000, 16'd10000, 16'd65535, 1'b1);
        push(CMD_START, 1'b1, 10'd0, 1'b1);
        push_ticks(3, 1'b1);
        drain();
        write_reg(REG_PULSE_W, 16'd0);
        write_reg(REG_PRE_DLY, 16'd0);
        push_ticks(5, 1'b1);
        drain();
        write_reg(REG_READY_TMO, 16'd0);
        push_ticks(1, 1'b1);
        push(CMD_START, 1'b1, 10'd0, 1'b0);
        push_ticks(4, 1'b0);
        drain();
        write_reg(REG_POST_DLY, 16'd1);
        push_ticks(1, 1'b0);
        drain();

        // long test pulse, no idling on either side
        in_gap_max  = 0;
        out_gap_max = 0;
        push(CMD_TEST, 1'b0, 10'd300, 1'b0);
        for (k = 0; k < 303; k++)
            push(CMD_TICK, 1'($urandom_range(0, 1)), PW_W'($urandom_range(0, 1000)),
                 1'($urandom_range(0, 1)));
        drain();

        for (ph_idx = 0; ph_idx < 8; ph_idx++) begin
            case (ph_idx)
                0: set_config(1'b1, 16'd1, 16'd0, 16'd0, 16'd0, 1'b1);
                1: set_config(1'b0, 16'd2, 16'd1, 16'd1, 16'd2, 1'b1);
                default: set_config($urandom_range(0, 4) != 0,
                                    CDATA_W'($urandom_range(0, 4)),
                                    CDATA_W'($urandom_range(0, 4)),
                                    CDATA_W'($urandom_range(0, 4)),
                                    CDATA_W'($urandom_range(0, 6)),
                                    1'($urandom_range(0, 1)));
            endcase
            in_gap_max  = (ph_idx == 3) ? 0 : 17;
            out_gap_max = (ph_idx == 5) ? 0 : 17;
            for (k = 0; k < 75; k++) begin
                if (ph_idx == 4 && k == 37)
                    drain();
                push_req(rand_item());
            end
            drain();
        end

        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            err_cnt++;
        end
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
